### rtl/itrpm_pkg.sv
// ----------------------------------------------------------------------------
// itrpm_pkg
// Shared constants and types of the image to road point mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package itrpm_pkg;

  localparam int IMAGE_ROWS = 1080;
  localparam int ROW_W      = $clog2(IMAGE_ROWS);

  localparam int CORNER_W = 22;
  localparam int PIX_W    = 11;
  localparam int DIST_W   = 24;
  localparam int PLAN_W   = 12;
  localparam int OUT_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam int QFRAC  = 16;
  localparam int DIV_NW = 56;
  localparam int DIV_DW = 44;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_MAP  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORNER_A    = 3'd0,
    REG_CORNER_B    = 3'd1,
    REG_CORNER_C    = 3'd2,
    REG_CORNER_D    = 3'd3,
    REG_PLAN_WIDTH  = 3'd4,
    REG_PLAN_LENGTH = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [CORNER_W-1:0] corner_a;
    logic [CORNER_W-1:0] corner_b;
    logic [CORNER_W-1:0] corner_c;
    logic [CORNER_W-1:0] corner_d;
    logic [PLAN_W-1:0]   plan_width;
    logic [PLAN_W-1:0]   plan_length;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/itrpm_div.sv
// ----------------------------------------------------------------------------
// itrpm_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module itrpm_div import itrpm_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic [DIV_NW-1:0] quo_o
);

  logic [DIV_DW-1:0] rem_q [DIV_NW];
  logic [DIV_DW-1:0] rem_d [DIV_NW];
  logic [DIV_NW-1:0] num_q [DIV_NW];
  logic [DIV_NW-1:0] num_d [DIV_NW];
  logic [DIV_NW-1:0] quo_q [DIV_NW];
  logic [DIV_NW-1:0] quo_d [DIV_NW];
  logic [DIV_DW-1:0] den_q [DIV_NW];
  logic [DIV_DW-1:0] den_d [DIV_NW];

  always_comb begin
    logic [DIV_DW-1:0] pr;
    logic [DIV_DW-1:0] pd;
    logic [DIV_NW-1:0] pn;
    logic [DIV_NW-1:0] pq;
    logic [DIV_DW:0]   sh;
    logic [DIV_DW:0]   df;
    logic              ge;
    for (int k = 0; k < DIV_NW; k++) begin
      if (k == 0) begin
        pr = '0;
        pn = num_i;
        pq = '0;
        pd = den_i;
      end else begin
        pr = rem_q[k-1];
        pn = num_q[k-1];
        pq = quo_q[k-1];
        pd = den_q[k-1];
      end
      sh = {pr, pn[DIV_NW-1]};
      df = sh - {1'b0, pd};
      ge = (sh >= {1'b0, pd});
      rem_d[k] = ge ? df[DIV_DW-1:0] : sh[DIV_DW-1:0];
      num_d[k] = {pn[DIV_NW-2:0], 1'b0};
      quo_d[k] = {pq[DIV_NW-2:0], ge};
      den_d[k] = pd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      num_q <= num_d;
      quo_q <= quo_d;
      den_q <= den_d;
    end
  end

  assign quo_o = quo_q[DIV_NW-1];

endmodule

`default_nettype wire

### rtl/itrpm_table.sv
// ----------------------------------------------------------------------------
// itrpm_table
// Row distance table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module itrpm_table import itrpm_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [ROW_W-1:0]  waddr_i,
  input  logic [DIST_W-1:0] wdata_i,
  input  logic [ROW_W-1:0]  raddr_a_i,
  input  logic [ROW_W-1:0]  raddr_b_i,
  output logic [DIST_W-1:0] rdata_a_o,
  output logic [DIST_W-1:0] rdata_b_o
);

  logic [DIST_W-1:0] mem_q [IMAGE_ROWS];
  logic [DIST_W-1:0] rdata_a_q;
  logic [DIST_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

### rtl/image_to_road_point_mapper.sv
// ----------------------------------------------------------------------------
// image_to_road_point_mapper
// Maps a pixel onto a road plan through edge intersections and a row table.
//
//   channel  dir  fields
//   s_axis   in   tuser: operation; tdata: table_row, table_value, pixel_x,
//                 pixel_y
//   m_axis   out  tuser: degenerate; tdata: plan_x, plan_y
//   cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// One beat per cycle unless stalled; a map beat's result passes through two
// 56-stage divider pipelines in series. Load beats write the table
// in order with map beats and give no result.
// A held output beat parks the next one in a skid register; a full skid stalls
// the whole pipeline. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module image_to_road_point_mapper import itrpm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CORNER_W-1:0]  cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,  // table_row, table_value, pixel_x, pixel_y
  input  logic                 s_axis_tuser,  // operation
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,  // plan_x, plan_y
  output logic                 m_axis_tuser   // degenerate
);

  localparam int V_W  = 13;
  localparam int M_W  = 26;
  localparam int T_W  = 39;
  localparam int N_W  = 41;
  localparam int D_W  = 27;
  localparam int Q_W  = 42;
  localparam int VQ_W = V_W + QFRAC;
  localparam int R_W  = Q_W - QFRAC + 2;
  localparam int X_W  = 43;
  localparam int XN_W = 55;
  localparam int YN_W = DIST_W + PLAN_W;
  localparam logic signed [V_W-1:0] ROWS_V = V_W'(IMAGE_ROWS);
  localparam logic [DIV_NW-1:0] QLIM = DIV_NW'(1) << 40;

  typedef struct packed {
    logic              vld;
    op_e               op;
    logic [PIX_W-1:0]  row;
    logic [DIST_W-1:0] value;
    logic [PIX_W-1:0]  px;
    logic [PIX_W-1:0]  py;
  } in_t;

  typedef struct packed {
    logic                  vld;
    op_e                   op;
    logic [PIX_W-1:0]      row;
    logic [DIST_W-1:0]     value;
    logic signed [V_W-1:0] v;
    logic signed [V_W-1:0] dxa;
    logic signed [V_W-1:0] dxb;
    logic signed [M_W-1:0] m1;
    logic signed [M_W-1:0] m2;
    logic signed [M_W-1:0] m3;
    logic signed [M_W-1:0] m4;
    logic signed [M_W-1:0] m5;
    logic signed [M_W-1:0] m6;
    logic                  deg;
  } p1_t;

  typedef struct packed {
    logic                  vld;
    op_e                   op;
    logic [PIX_W-1:0]      row;
    logic [DIST_W-1:0]     value;
    logic signed [V_W-1:0] v;
    logic signed [T_W-1:0] t0;
    logic signed [T_W-1:0] t1;
    logic signed [T_W-1:0] t2;
    logic signed [T_W-1:0] u0;
    logic signed [T_W-1:0] u1;
    logic signed [T_W-1:0] u2;
    logic signed [D_W-1:0] d12;
    logic signed [D_W-1:0] d13;
    logic                  deg;
  } p2_t;

  typedef struct packed {
    logic                  vld;
    op_e                   op;
    logic [PIX_W-1:0]      row;
    logic [DIST_W-1:0]     value;
    logic signed [V_W-1:0] v;
    logic signed [N_W-1:0] n0;
    logic signed [N_W-1:0] n1;
    logic signed [D_W-1:0] d12;
    logic signed [D_W-1:0] d13;
    logic                  deg;
  } p3_t;

  typedef struct packed {
    logic                  vld;
    op_e                   op;
    logic [PIX_W-1:0]      row;
    logic [DIST_W-1:0]     value;
    logic signed [V_W-1:0] v;
    logic                  deg;
    logic                  neg0;
    logic                  neg1;
  } sb1_t;

  typedef struct packed {
    logic                  vld;
    op_e                   op;
    logic [PIX_W-1:0]      row;
    logic [DIST_W-1:0]     value;
    logic signed [V_W-1:0] v;
    logic signed [Q_W-1:0] v0;
    logic signed [Q_W-1:0] v1;
    logic                  deg;
  } pa_t;

  typedef struct packed {
    logic                  vld;
    logic                  deg;
    logic signed [X_W-1:0] diffn;
    logic signed [X_W-1:0] diffd;
  } pb_t;

  typedef struct packed {
    logic                   vld;
    logic                   deg;
    logic signed [XN_W-1:0] xnum;
    logic signed [X_W-1:0]  xden;
    logic [YN_W-1:0]        ynum;
    logic [DIST_W-1:0]      yden;
  } pc_t;

  typedef struct packed {
    logic vld;
    logic deg;
    logic xneg;
  } sb2_t;

  function automatic logic signed [Q_W-1:0] sat_q(input logic [DIV_NW-1:0] q,
                                                  input logic neg);
    logic [Q_W-1:0] m;
    m = (q > QLIM) ? QLIM[Q_W-1:0] : q[Q_W-1:0];
    return neg ? $signed(-m) : $signed(m);
  endfunction

  function automatic logic [ROW_W-1:0] clamp_row(input logic signed [R_W-1:0] r);
    logic [ROW_W-1:0] res;
    if (r < 0) begin
      res = '0;
    end else if (r > R_W'(IMAGE_ROWS - 1)) begin
      res = ROW_W'(IMAGE_ROWS - 1);
    end else begin
      res = r[ROW_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [OUT_W-1:0] out16(input logic [DIV_NW-1:0] q,
                                             input logic neg);
    logic [OUT_W-1:0] res;
    if (!neg) begin
      res = (q > DIV_NW'(32767)) ? 16'h7fff : q[OUT_W-1:0];
    end else begin
      res = (q > DIV_NW'(32768)) ? 16'h8000 : (16'd0 - q[OUT_W-1:0]);
    end
    return res;
  endfunction

  cfg_t cfg_q;
  logic en;
  in_t  in_q;
  p1_t  p1_q, p1_d;
  p2_t  p2_q, p2_d;
  p3_t  p3_q, p3_d;
  sb1_t sb1_q [DIV_NW];
  sb1_t sb1_d;
  pa_t  pa_q, pa_d;
  pb_t  pb_q, pb_d;
  pc_t  pc_q, pc_d;
  sb2_t sb2_q [DIV_NW];
  sb2_t sb2_d;
  logic              out_vld_q;
  logic [31:0]       out_data_q;
  logic              out_deg_q;
  logic              skid_vld_q;
  logic [31:0]       skid_data_q;
  logic              skid_deg_q;
  logic              pipe_vld;
  logic [31:0]       pipe_data;
  logic              pipe_deg;

  logic signed [V_W-1:0] ax, av, bx, bv, cx, cv, dx, dv;
  logic signed [V_W-1:0] ex1, ev1, ex2, ev2, ex3, ev3;

  logic [DIV_NW-1:0] num0, num1, xnum_mag, ynum_ext, q0, q1, qx, qy;
  logic [DIV_DW-1:0] den0, den1, xden_mag, yden_ext;
  logic [N_W-1:0]    n0_mag, n1_mag;
  logic [D_W-1:0]    d12_mag, d13_mag;
  logic [XN_W-1:0]   xn_mag;
  logic [X_W-1:0]    xd_mag;

  logic              tab_we;
  logic [ROW_W-1:0]  tab_idx, tab_ref;
  logic [DIST_W-1:0] rd_idx, rd_ref;
  logic signed [VQ_W-1:0] pa_vq;
  logic [Q_W-1:0]    v0_mag;
  logic signed [R_W-1:0] v0_int, idx_r;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_CORNER_A:    cfg_q.corner_a    <= cfg_data_i;
        REG_CORNER_B:    cfg_q.corner_b    <= cfg_data_i;
        REG_CORNER_C:    cfg_q.corner_c    <= cfg_data_i;
        REG_CORNER_D:    cfg_q.corner_d    <= cfg_data_i;
        REG_PLAN_WIDTH:  cfg_q.plan_width  <= cfg_data_i[PLAN_W-1:0];
        REG_PLAN_LENGTH: cfg_q.plan_length <= cfg_data_i[PLAN_W-1:0];
        default: ;
      endcase
    end
  end

  // corner geometry, rows flipped so that v grows upward
  always_comb begin
    ax  = $signed(V_W'(cfg_q.corner_a[CORNER_W-1:PIX_W]));
    bx  = $signed(V_W'(cfg_q.corner_b[CORNER_W-1:PIX_W]));
    cx  = $signed(V_W'(cfg_q.corner_c[CORNER_W-1:PIX_W]));
    dx  = $signed(V_W'(cfg_q.corner_d[CORNER_W-1:PIX_W]));
    av  = ROWS_V - $signed(V_W'(cfg_q.corner_a[PIX_W-1:0]));
    bv  = ROWS_V - $signed(V_W'(cfg_q.corner_b[PIX_W-1:0]));
    cv  = ROWS_V - $signed(V_W'(cfg_q.corner_c[PIX_W-1:0]));
    dv  = ROWS_V - $signed(V_W'(cfg_q.corner_d[PIX_W-1:0]));
    ex1 = dx - cx;
    ev1 = dv - cv;
    ex2 = dx - ax;
    ev2 = dv - av;
    ex3 = cx - bx;
    ev3 = cv - bv;
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (en) begin
      in_q.vld   <= s_axis_tvalid;
      in_q.op    <= op_e'(s_axis_tuser);
      in_q.row   <= s_axis_tdata[10:0];
      in_q.value <= s_axis_tdata[34:11];
      in_q.px    <= s_axis_tdata[45:35];
      in_q.py    <= s_axis_tdata[56:46];
    end
  end

  // edge products
  always_comb begin
    p1_d.vld   = in_q.vld;
    p1_d.op    = in_q.op;
    p1_d.row   = in_q.row;
    p1_d.value = in_q.value;
    p1_d.v     = ROWS_V - $signed(V_W'(in_q.py));
    p1_d.dxa   = $signed(V_W'(in_q.px)) - ax;
    p1_d.dxb   = $signed(V_W'(in_q.px)) - bx;
    p1_d.m1    = M_W'(ev1 * ev2);
    p1_d.m2    = M_W'(ev2 * ex1);
    p1_d.m3    = M_W'(ev1 * ex2);
    p1_d.m4    = M_W'(ev1 * ev3);
    p1_d.m5    = M_W'(ev3 * ex1);
    p1_d.m6    = M_W'(ev1 * ex3);
    p1_d.deg   = (ex1 == 0) || (ex2 == 0) || (ex3 == 0);
  end

  always_comb begin
    p2_d.vld   = p1_q.vld;
    p2_d.op    = p1_q.op;
    p2_d.row   = p1_q.row;
    p2_d.value = p1_q.value;
    p2_d.v     = p1_q.v;
    p2_d.t0    = T_W'($signed(p1_q.m1) * $signed(p1_q.dxa));
    p2_d.t1    = T_W'($signed(p1_q.m2) * $signed(p1_q.v));
    p2_d.t2    = T_W'($signed(p1_q.m3) * av);
    p2_d.u0    = T_W'($signed(p1_q.m4) * $signed(p1_q.dxb));
    p2_d.u1    = T_W'($signed(p1_q.m5) * $signed(p1_q.v));
    p2_d.u2    = T_W'($signed(p1_q.m6) * bv);
    p2_d.d12   = D_W'($signed(p1_q.m3) - $signed(p1_q.m2));
    p2_d.d13   = D_W'($signed(p1_q.m6) - $signed(p1_q.m5));
    p2_d.deg   = p1_q.deg;
  end

  always_comb begin
    p3_d.vld   = p2_q.vld;
    p3_d.op    = p2_q.op;
    p3_d.row   = p2_q.row;
    p3_d.value = p2_q.value;
    p3_d.v     = p2_q.v;
    p3_d.n0    = N_W'($signed(p2_q.t0) - $signed(p2_q.t1) + $signed(p2_q.t2));
    p3_d.n1    = N_W'($signed(p2_q.u0) - $signed(p2_q.u1) + $signed(p2_q.u2));
    p3_d.d12   = p2_q.d12;
    p3_d.d13   = p2_q.d13;
    p3_d.deg   = p2_q.deg || (p2_q.d12 == 0) || (p2_q.d13 == 0);
  end

  // intersection divides
  always_comb begin
    n0_mag  = p3_q.n0[N_W-1] ? N_W'(-p3_q.n0) : N_W'(p3_q.n0);
    n1_mag  = p3_q.n1[N_W-1] ? N_W'(-p3_q.n1) : N_W'(p3_q.n1);
    d12_mag = p3_q.d12[D_W-1] ? D_W'(-p3_q.d12) : D_W'(p3_q.d12);
    d13_mag = p3_q.d13[D_W-1] ? D_W'(-p3_q.d13) : D_W'(p3_q.d13);
    num0    = {n0_mag[DIV_NW-QFRAC-1:0], {QFRAC{1'b0}}};
    num1    = {n1_mag[DIV_NW-QFRAC-1:0], {QFRAC{1'b0}}};
    den0    = DIV_DW'(d12_mag);
    den1    = DIV_DW'(d13_mag);
    sb1_d.vld   = p3_q.vld;
    sb1_d.op    = p3_q.op;
    sb1_d.row   = p3_q.row;
    sb1_d.value = p3_q.value;
    sb1_d.v     = p3_q.v;
    sb1_d.deg   = p3_q.deg;
    sb1_d.neg0  = p3_q.n0[N_W-1] ^ p3_q.d12[D_W-1];
    sb1_d.neg1  = p3_q.n1[N_W-1] ^ p3_q.d13[D_W-1];
  end

  itrpm_div u_div_v0 (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num0),
    .den_i (den0),
    .quo_o (q0)
  );

  itrpm_div u_div_v1 (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num1),
    .den_i (den1),
    .quo_o (q1)
  );

  always_comb begin
    pa_d.vld   = sb1_q[DIV_NW-1].vld;
    pa_d.op    = sb1_q[DIV_NW-1].op;
    pa_d.row   = sb1_q[DIV_NW-1].row;
    pa_d.value = sb1_q[DIV_NW-1].value;
    pa_d.v     = sb1_q[DIV_NW-1].v;
    pa_d.v0    = sat_q(q0, sb1_q[DIV_NW-1].neg0);
    pa_d.v1    = sat_q(q1, sb1_q[DIV_NW-1].neg1);
    pa_d.deg   = sb1_q[DIV_NW-1].deg;
  end

  // table access and split differences
  always_comb begin
    pa_vq   = {pa_q.v, {QFRAC{1'b0}}};
    v0_mag  = pa_q.v0[Q_W-1] ? Q_W'(-pa_q.v0) : Q_W'(pa_q.v0);
    v0_int  = pa_q.v0[Q_W-1] ? -$signed(R_W'(v0_mag >> QFRAC))
                             : $signed(R_W'(v0_mag >> QFRAC));
    idx_r   = $signed(R_W'(IMAGE_ROWS)) - v0_int;
    tab_idx = clamp_row(idx_r);
    tab_ref = clamp_row($signed(R_W'(cfg_q.corner_d[PIX_W-1:0])));
    tab_we  = pa_q.vld && (pa_q.op == OP_LOAD) && (32'(pa_q.row) < 32'(IMAGE_ROWS));
    pb_d.vld   = pa_q.vld && (pa_q.op == OP_MAP);
    pb_d.deg   = pa_q.deg || (pa_q.v0 == pa_q.v1) || (Q_W'(pa_vq) == pa_q.v1);
    pb_d.diffn = X_W'($signed(pa_q.v0) - $signed(pa_vq));
    pb_d.diffd = X_W'($signed(pa_q.v0) - $signed(pa_q.v1));
  end

  itrpm_table u_table (
    .clk_i     (clk_i),
    .en_i      (en),
    .we_i      (tab_we),
    .waddr_i   (ROW_W'(pa_q.row)),
    .wdata_i   (pa_q.value),
    .raddr_a_i (tab_idx),
    .raddr_b_i (tab_ref),
    .rdata_a_o (rd_idx),
    .rdata_b_o (rd_ref)
  );

  always_comb begin
    pc_d.vld  = pb_q.vld;
    pc_d.deg  = pb_q.deg || (rd_ref == '0);
    pc_d.xnum = XN_W'($signed({1'b0, cfg_q.plan_width}) * $signed(pb_q.diffn));
    pc_d.xden = pb_q.diffd;
    pc_d.ynum = YN_W'(rd_idx) * YN_W'(cfg_q.plan_length);
    pc_d.yden = rd_ref;
  end

  // plan divides
  always_comb begin
    xn_mag   = pc_q.xnum[XN_W-1] ? XN_W'(-pc_q.xnum) : XN_W'(pc_q.xnum);
    xd_mag   = pc_q.xden[X_W-1] ? X_W'(-pc_q.xden) : X_W'(pc_q.xden);
    xnum_mag = DIV_NW'(xn_mag);
    xden_mag = DIV_DW'(xd_mag);
    ynum_ext = DIV_NW'(pc_q.ynum);
    yden_ext = DIV_DW'(pc_q.yden);
    sb2_d.vld  = pc_q.vld;
    sb2_d.deg  = pc_q.deg;
    sb2_d.xneg = pc_q.xnum[XN_W-1] ^ pc_q.xden[X_W-1];
  end

  itrpm_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (xnum_mag),
    .den_i (xden_mag),
    .quo_o (qx)
  );

  itrpm_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (ynum_ext),
    .den_i (yden_ext),
    .quo_o (qy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q  <= '0;
      p2_q  <= '0;
      p3_q  <= '0;
      sb1_q <= '{default: '0};
      pa_q  <= '0;
      pb_q  <= '0;
      pc_q  <= '0;
      sb2_q <= '{default: '0};
    end else if (en) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
      sb1_q[0] <= sb1_d;
      for (int k = 1; k < DIV_NW; k++) begin
        sb1_q[k] <= sb1_q[k-1];
      end
      pa_q <= pa_d;
      pb_q <= pb_d;
      pc_q <= pc_d;
      sb2_q[0] <= sb2_d;
      for (int k = 1; k < DIV_NW; k++) begin
        sb2_q[k] <= sb2_q[k-1];
      end
    end
  end

  always_comb begin
    pipe_vld  = sb2_q[DIV_NW-1].vld;
    pipe_deg  = sb2_q[DIV_NW-1].deg;
    pipe_data = pipe_deg ? '0 : {out16(qy, 1'b0), out16(qx, sb2_q[DIV_NW-1].xneg)};
  end

  // output register with one-beat skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q   <= 1'b0;
      out_data_q  <= '0;
      out_deg_q   <= 1'b0;
      skid_vld_q  <= 1'b0;
      skid_data_q <= '0;
      skid_deg_q  <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q  <= skid_vld_q || pipe_vld;
      out_data_q <= skid_vld_q ? skid_data_q : pipe_data;
      out_deg_q  <= skid_vld_q ? skid_deg_q : pipe_deg;
      skid_vld_q <= 1'b0;
    end else if (!skid_vld_q) begin
      skid_vld_q  <= pipe_vld;
      skid_data_q <= pipe_data;
      skid_deg_q  <= pipe_deg;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_deg_q;

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate beat with nonzero data");

  a_y_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> !m_axis_tdata[31])
    else $error("plan_y negative");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> $stable(pb_q) && $stable(pa_q))
    else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

### tb/tb_image_to_road_point_mapper.sv
// ----------------------------------------------------------------------------
// tb_image_to_road_point_mapper
// Self-checking testbench for the image to road point mapper. Fills the
// distance table, then runs directed and random map beats under several
// corner and plan settings with random input gaps and output stalls. Each
// result is predicted in the bench and compared in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_image_to_road_point_mapper;
  import itrpm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int  DRAIN_CYCLES = 140;
  localparam int  IDLE_LIMIT   = 5000;
  localparam longint QUNIT     = 65536;
  localparam longint QMAX      = longint'(1) << 40;

  typedef struct {
    logic signed [OUT_W-1:0] plan_x;
    logic signed [OUT_W-1:0] plan_y;
    logic                    degenerate;
  } road_point_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CORNER_W-1:0]  cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata = '0;  // table_row, table_value, pixel_x, pixel_y
  logic                 s_axis_tuser = 1'b0;  // operation
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;  // plan_x, plan_y
  logic                 m_axis_tuser;  // degenerate

  image_to_road_point_mapper u_top (.*);

  always #4 clk_i = ~clk_i;

  logic [CORNER_W-1:0] corner_q [4];
  logic [PLAN_W-1:0]   width_q, length_q;
  logic [DIST_W-1:0]   dist_q [IMAGE_ROWS];
  road_point_t         point_q [$];
  int                  errors = 0;
  int                  burst_left = 0;
  int                  idle_cycles = 0;
  int                  rx_cycle = 0;

  function automatic longint clamp_row(longint r);
    if (r < 0) return 0;
    if (r > IMAGE_ROWS - 1) return IMAGE_ROWS - 1;
    return r;
  endfunction

  function automatic longint sat_q(longint q);
    if (q > QMAX) return QMAX;
    if (q < -QMAX) return -QMAX;
    return q;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat16(longint q);
    if (q > 32767) return 16'sh7fff;
    if (q < -32768) return 16'sh8000;
    return q[OUT_W-1:0];
  endfunction

  function automatic road_point_t map_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    longint h, x, v, vq, ax, av, bx, bv, cx, cv, dx, dv;
    longint ex1, ev1, ex2, ev2, ex3, ev3, d12, d13, n0, n1, v0, v1, xm, yq, rr, ix;
    logic deg;
    road_point_t p;
    h = IMAGE_ROWS;
    x = px;
    v = h - longint'(py);
    ax = corner_q[0][21:11]; av = h - longint'(corner_q[0][10:0]);
    bx = corner_q[1][21:11]; bv = h - longint'(corner_q[1][10:0]);
    cx = corner_q[2][21:11]; cv = h - longint'(corner_q[2][10:0]);
    dx = corner_q[3][21:11]; dv = h - longint'(corner_q[3][10:0]);
    ex1 = dx - cx; ev1 = dv - cv;
    ex2 = dx - ax; ev2 = dv - av;
    ex3 = cx - bx; ev3 = cv - bv;
    deg = (ex1 == 0 || ex2 == 0 || ex3 == 0);
    d12 = ev1 * ex2 - ev2 * ex1;
    d13 = ev1 * ex3 - ev3 * ex1;
    if (d12 == 0 || d13 == 0) deg = 1'b1;
    vq = v * QUNIT;
    v0 = 0; v1 = 0; xm = 0; yq = 0;
    if (!deg) begin
      n0 = ev1 * ev2 * (x - ax) - ev2 * ex1 * v + ev1 * ex2 * av;
      n1 = ev1 * ev3 * (x - bx) - ev3 * ex1 * v + ev1 * ex3 * bv;
      v0 = sat_q(n0 * QUNIT / d12);
      v1 = sat_q(n1 * QUNIT / d13);
      if (v0 == v1 || vq == v1) deg = 1'b1;
    end
    rr = clamp_row(longint'(corner_q[3][10:0]));
    if (dist_q[rr] == 0) deg = 1'b1;
    if (!deg) begin
      ix = clamp_row(h - v0 / QUNIT);
      xm = longint'(width_q) * (v0 - vq) / (v0 - v1);
      yq = longint'(dist_q[ix]) * longint'(length_q) / longint'(dist_q[rr]);
    end
    p.plan_x = deg ? '0 : sat16(xm);
    p.plan_y = deg ? '0 : sat16(yq);
    p.degenerate = deg;
    return p;
  endfunction

  task automatic send_beat(op_e op, logic [10:0] row, logic [23:0] val,
                           logic [10:0] px, logic [10:0] py);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, py, px, val, row};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_MAP) point_q.insert(point_q.size(), map_pixel(px, py));
    else if (row < IMAGE_ROWS) dist_q[row] = val;
    burst_left--;
  endtask

  task automatic map_beat(logic [10:0] px, logic [10:0] py);
    send_beat(OP_MAP, 11'($urandom), 24'($urandom), px, py);
  endtask

  task automatic load_beat(logic [10:0] row, logic [23:0] val);
    send_beat(OP_LOAD, row, val, 11'($urandom), 11'($urandom));
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (point_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CORNER_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_CORNER_A:    corner_q[0] = data;
      REG_CORNER_B:    corner_q[1] = data;
      REG_CORNER_C:    corner_q[2] = data;
      REG_CORNER_D:    corner_q[3] = data;
      REG_PLAN_WIDTH:  width_q = data[PLAN_W-1:0];
      REG_PLAN_LENGTH: length_q = data[PLAN_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [CORNER_W-1:0] corner(int x, int y);
    return {11'(x), 11'(y)};
  endfunction

  task automatic set_plan(int a, int b, int c, int d, int w, int l);
    drain();
    write_reg(REG_CORNER_A, corner_q[0] ^ 22'h0);
    write_reg(REG_CORNER_A, 22'(a));
    write_reg(REG_CORNER_B, 22'(b));
    write_reg(REG_CORNER_C, 22'(c));
    write_reg(REG_CORNER_D, 22'(d));
    write_reg(REG_PLAN_WIDTH, 22'(w));
    write_reg(REG_PLAN_LENGTH, 22'(l));
  endtask

  task automatic set_trapezoid(int w, int l);
    set_plan(corner($urandom_range(600, 900), $urandom_range(150, 450)),
             corner($urandom_range(1100, 1400), $urandom_range(150, 450)),
             corner($urandom_range(1600, 2047), $urandom_range(900, 1079)),
             corner($urandom_range(0, 400), $urandom_range(900, 1079)), w, l);
  endtask

  task automatic test_fill_table();
    for (int r = 0; r < IMAGE_ROWS; r++) begin
      case ($urandom_range(0, 19))
        0:       load_beat(11'(r), 24'hffffff);
        1:       load_beat(11'(r), 24'd0);
        default: load_beat(11'(r), 24'($urandom_range(1, 24'hffffff)));
      endcase
      if (r % 40 == 0) load_beat(11'($urandom_range(IMAGE_ROWS, 2047)), 24'($urandom));
    end
    load_beat(11'd2047, 24'hffffff);
  endtask

  task automatic test_directed();
    int d_row;
    set_plan(corner(800, 300), corner(1200, 300), corner(1900, 1000),
             corner(100, 1000), 4095, 4095);
    load_beat(11'd1000, 24'h000100);
    map_beat(11'd0, 11'd0);
    map_beat(11'd2047, 11'd1079);
    map_beat(11'd1000, 11'd600);
    map_beat(11'd0, 11'd1079);
    map_beat(11'd2047, 11'd0);
    map_beat(11'd100, 11'd1000);
    map_beat(11'd1900, 11'd1000);
    map_beat(11'd1000, 11'd1000);
    // zero reference distance
    load_beat(11'd1000, 24'd0);
    map_beat(11'd1000, 11'd600);
    load_beat(11'd1000, 24'hffffff);
    map_beat(11'd1000, 11'd600);
    set_plan(corner(100, 300), corner(1200, 300), corner(1900, 1000),
             corner(100, 1000), 0, 0);
    map_beat(11'd500, 11'd500);
    set_plan(corner(800, 300), corner(1200, 300), corner(1900, 1000),
             corner(1900, 1000), 100, 100);
    map_beat(11'd500, 11'd500);
    set_plan(corner(200, 200), corner(1200, 300), corner(1900, 1000),
             corner(100, 1000), 100, 100);
    map_beat(11'd500, 11'd500);
    set_plan(22'h3fffff, 22'h3fffff, 22'h3fffff, 22'h3fffff, 4095, 4095);
    map_beat(11'd2047, 11'd1079);
    set_plan(0, 0, 0, 0, 0, 0);
    write_reg(REG_UNUSED, 22'h3fffff);
    map_beat(11'd0, 11'd0);
    set_plan(corner(0, 0), corner(2047, 0), corner(2047, 2047), corner(0, 1079), 4095, 1);
    map_beat(11'd1024, 11'd540);
    d_row = 1079;
    map_beat(11'd5, 11'(d_row));
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_trapezoid(4095, 4095);
        1: set_trapezoid(0, 0);
        2: set_trapezoid(1, 4095);
        3: set_plan($urandom_range(0, 22'h3fffff), $urandom_range(0, 22'h3fffff),
                    $urandom_range(0, 22'h3fffff), $urandom_range(0, 22'h3fffff),
                    $urandom_range(0, 4095), $urandom_range(0, 4095));
        default: set_trapezoid($urandom_range(0, 4095), $urandom_range(0, 4095));
      endcase
      repeat (100) begin
        if ($urandom_range(0, 9) == 0)
          load_beat(11'($urandom_range(0, 2047)), 24'($urandom));
        else
          map_beat(11'($urandom_range(0, 2047)), 11'($urandom_range(0, IMAGE_ROWS - 1)));
      end
    end
  endtask

  always @(negedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if ((rx_cycle / 1000) % 2 == 0) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk_i) begin
    road_point_t exp_p;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (point_q.size() == 0) begin
        $display("%t unexpected result: %h deg %b", $realtime, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        exp_p = point_q.pop_front();
        if (m_axis_tdata[15:0] !== exp_p.plan_x) begin
          $display("%t plan_x expected %0d actual %0d", $realtime, exp_p.plan_x,
                   $signed(m_axis_tdata[15:0]));
          errors++;
        end
        if (m_axis_tdata[31:16] !== exp_p.plan_y) begin
          $display("%t plan_y expected %0d actual %0d", $realtime, exp_p.plan_y,
                   $signed(m_axis_tdata[31:16]));
          errors++;
        end
        if (m_axis_tuser !== exp_p.degenerate) begin
          $display("%t degenerate expected %b actual %b", $realtime, exp_p.degenerate,
                   m_axis_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_image_to_road_point_mapper NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (corner_q[i]) corner_q[i] = '0;
    width_q = '0;
    length_q = '0;
    foreach (dist_q[i]) dist_q[i] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_fill_table();
    test_directed();
    test_random();
    drain();
    if (errors == 0) begin
      $display("tb_image_to_road_point_mapper OK");
    end else begin
      $display("tb_image_to_road_point_mapper NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
